// File: rtl/mqfc_pkg.sv
// Package for the mirrored quad framed compositor.
// Holds the request, response and register types, codes and size helpers.
// No dependencies.
package mqfc_pkg;

   localparam int MAX_SOURCE_WIDTH_DEF  = 512;
   localparam int MAX_SOURCE_HEIGHT_DEF = 512;
   localparam int FRAME_MAX             = 31;
   localparam int CFG_DIM_W             = 10;
   localparam int CFG_FRAME_W           = 5;
   localparam int CSR_INDEX_W           = 3;
   localparam int CSR_DATA_W            = 10;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EMIT = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_WIDTH  = 3'd0,
      CSR_SOURCE_HEIGHT = 3'd1,
      CSR_BORDER_WIDTH  = 3'd2,
      CSR_FRAME_RED     = 3'd3,
      CSR_FRAME_GREEN   = 3'd4,
      CSR_FRAME_BLUE    = 3'd5
   } csr_index_type;

   typedef struct packed {
      opcode_type opcode;
      logic [7:0] pixel_blue;
      logic [7:0] pixel_green;
      logic [7:0] pixel_red;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic       last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0]   source_width;
      logic [CFG_DIM_W-1:0]   source_height;
      logic [CFG_FRAME_W-1:0] border_width;
      logic [7:0]             frame_red;
      logic [7:0]             frame_green;
      logic [7:0]             frame_blue;
   } cfg_type;

   // Per-emit control that travels from the sequencer to the output stage
   typedef struct packed {
      logic frame;
      logic last;
   } emit_info_type;

   localparam logic [CFG_DIM_W-1:0]   SOURCE_WIDTH_RST  = 10'd512;
   localparam logic [CFG_DIM_W-1:0]   SOURCE_HEIGHT_RST = 10'd512;
   localparam logic [CFG_FRAME_W-1:0] BORDER_WIDTH_RST  = 5'd4;

   // Index bits of the reduced store along one axis of source size n
   function automatic int red_bits(input int n);
      int r;
      r = $clog2((n + 1) / 2);
      return (r < 1) ? 1 : r;
   endfunction

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// File: rtl/mirrored_quad_framed_compositor.sv
// An emit request gives its pixel on rsp after the store read register and
// then the output register; a load request gives no response.
// Throughput: one request per cycle while rsp_ready is high; the single
// store port pair (one write, one read per cycle) sets that rate.
// Reset: synchronous; clears counters, registers to defaults, and pipeline
// valids. Store contents stay undefined until loaded; no clearing pass.
module mirrored_quad_framed_compositor
   import mqfc_pkg::*;
#(
   parameter int MAX_SOURCE_WIDTH  = MAX_SOURCE_WIDTH_DEF,
   parameter int MAX_SOURCE_HEIGHT = MAX_SOURCE_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = red_bits(MAX_SOURCE_HEIGHT) + red_bits(MAX_SOURCE_WIDTH);

   cfg_type       cfg_ff;
   logic          s1_valid_ff;
   emit_info_type s1_info_ff;
   logic          out_valid_ff;
   rsp_type       out_data_ff;

   logic          req_fire, load_fire, emit_fire, s1_move;
   logic          wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [23:0]   rd_data;
   emit_info_type info;

   // Register writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width  <= SOURCE_WIDTH_RST;
         cfg_ff.source_height <= SOURCE_HEIGHT_RST;
         cfg_ff.border_width  <= BORDER_WIDTH_RST;
         cfg_ff.frame_red     <= '0;
         cfg_ff.frame_green   <= '0;
         cfg_ff.frame_blue    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  cfg_ff.source_width  <= csr_data;
            CSR_SOURCE_HEIGHT: cfg_ff.source_height <= csr_data;
            CSR_BORDER_WIDTH:  cfg_ff.border_width  <= csr_data[CFG_FRAME_W-1:0];
            CSR_FRAME_RED:     cfg_ff.frame_red     <= csr_data[7:0];
            CSR_FRAME_GREEN:   cfg_ff.frame_green   <= csr_data[7:0];
            CSR_FRAME_BLUE:    cfg_ff.frame_blue    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Advance the read stage into the output register when it is free or
   // being drained; take a new request whenever the read stage is empty or can move.
   assign s1_move   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_fire  = req_valid && req_ready;
   assign load_fire = req_fire && (req_data.opcode == OP_LOAD);
   assign emit_fire = req_fire && (req_data.opcode == OP_EMIT);

   mqfc_seq #(
      .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
      .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .load_fire (load_fire),
      .emit_fire (emit_fire),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .info      (info)
   );

   // A load written at one edge is visible to an emit read at the next, so
   // back-to-back load and emit of the same entry need no forwarding.
   mqfc_mem #(
      .ADDR_W (ADDR_W),
      .DATA_W (24)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_data.pixel_red, req_data.pixel_green, req_data.pixel_blue}),
      .rd_en   (emit_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read stage: hold emit control while the store read completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         s1_info_ff <= info;
      end
   end

   // Output register: select frame colour or stored pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         if (s1_info_ff.frame) begin
            out_data_ff.out_blue  <= cfg_ff.frame_blue;
            out_data_ff.out_green <= cfg_ff.frame_green;
            out_data_ff.out_red   <= cfg_ff.frame_red;
         end else begin
            out_data_ff.out_blue  <= rd_data[7:0];
            out_data_ff.out_green <= rd_data[15:8];
            out_data_ff.out_red   <= rd_data[23:16];
         end
         out_data_ff.last_pixel <= s1_info_ff.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: rtl/mqfc_mem.sv
// Reduced pixel store: one write port, one read port, registered read data.
// Depends on nothing.
module mqfc_mem #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mqfc_seq.sv
// Load and emit position counters with store address generation.
// Depends on mqfc_pkg.
module mqfc_seq
   import mqfc_pkg::*;
#(
   parameter int MAX_SOURCE_WIDTH  = MAX_SOURCE_WIDTH_DEF,
   parameter int MAX_SOURCE_HEIGHT = MAX_SOURCE_HEIGHT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          load_fire,
   input  logic          emit_fire,
   output logic          wr_en,
   output logic [red_bits(MAX_SOURCE_HEIGHT)+red_bits(MAX_SOURCE_WIDTH)-1:0] wr_addr,
   output logic [red_bits(MAX_SOURCE_HEIGHT)+red_bits(MAX_SOURCE_WIDTH)-1:0] rd_addr,
   output emit_info_type info
);

   localparam int JB    = red_bits(MAX_SOURCE_WIDTH);
   localparam int IB    = red_bits(MAX_SOURCE_HEIGHT);
   localparam int RED_W = (MAX_SOURCE_WIDTH + 1) / 2;
   localparam int RED_H = (MAX_SOURCE_HEIGHT + 1) / 2;
   localparam int ECB   = $clog2(2 * RED_W + 3 * FRAME_MAX);
   localparam int ERB   = $clog2(2 * RED_H + 3 * FRAME_MAX);
   localparam int XW    = max_int(max_int(ECB, ERB),
                             max_int(max_int($clog2(MAX_SOURCE_WIDTH + 1),
                                             $clog2(MAX_SOURCE_HEIGHT + 1)),
                                     CFG_DIM_W)) + 1;

   typedef logic [XW-1:0] ext_type;

   logic [JB:0]    load_col_ff, load_col_in;
   logic [IB:0]    load_row_ff, load_row_in;
   logic [ECB-1:0] emit_col_ff, emit_col_in;
   logic [ERB-1:0] emit_row_ff, emit_row_in;

   ext_type sw, sh, src_w, src_h, red_w, red_h, f, f2, cw, ch;
   ext_type lc, lr, lc_nxt, lr_nxt;
   ext_type ec, er, ec_nxt, er_nxt, i_idx, j_idx;
   logic    col_band, row_band;

   // clamp sizes and derive the composite geometry
   always_comb begin
      sw    = XW'(cfg.source_width);
      sh    = XW'(cfg.source_height);
      src_w = (sw == '0) ? XW'(1) : ((sw > XW'(MAX_SOURCE_WIDTH)) ? XW'(MAX_SOURCE_WIDTH) : sw);
      src_h = (sh == '0) ? XW'(1) : ((sh > XW'(MAX_SOURCE_HEIGHT)) ? XW'(MAX_SOURCE_HEIGHT) : sh);
      red_w = (src_w + XW'(1)) >> 1;
      red_h = (src_h + XW'(1)) >> 1;
      f     = XW'(cfg.border_width);
      f2    = f << 1;
      cw    = (red_w << 1) + f2 + f;
      ch    = (red_h << 1) + f2 + f;
   end

   // load side: keep even row, even column pixels
   always_comb begin
      lc = (XW'(load_col_ff) >= src_w) ? '0 : XW'(load_col_ff);
      lr = (XW'(load_row_ff) >= src_h) ? '0 : XW'(load_row_ff);
      lc_nxt = lc + XW'(1);
      lr_nxt = lr;
      if (lc_nxt >= src_w) begin
         lc_nxt = '0;
         lr_nxt = lr + XW'(1);
         if (lr_nxt >= src_h) begin
            lr_nxt = '0;
         end
      end
      load_col_in = (JB+1)'(lc_nxt);
      load_row_in = (IB+1)'(lr_nxt);
      wr_en   = load_fire && !lc[0] && !lr[0];
      wr_addr = {lr[IB:1], lc[JB:1]};
   end

   // emit side: band test, tile mirroring and raster advance
   always_comb begin
      ec = (XW'(emit_col_ff) >= cw) ? '0 : XW'(emit_col_ff);
      er = (XW'(emit_row_ff) >= ch) ? '0 : XW'(emit_row_ff);
      col_band = (ec < f) || ((ec >= f + red_w) && (ec < f2 + red_w)) ||
                 (ec >= f2 + (red_w << 1));
      row_band = (er < f) || ((er >= f + red_h) && (er < f2 + red_h)) ||
                 (er >= f2 + (red_h << 1));
      i_idx = (er >= f2 + red_h) ? er - (f2 + red_h) : f + red_h - XW'(1) - er;
      j_idx = (ec >= f2 + red_w) ? f2 + (red_w << 1) - XW'(1) - ec : ec - f;
      rd_addr    = {i_idx[IB-1:0], j_idx[JB-1:0]};
      info.frame = col_band || row_band;
      info.last  = (er == ch - XW'(1)) && (ec == cw - XW'(1));
      ec_nxt = ec + XW'(1);
      er_nxt = er;
      if (ec_nxt >= cw) begin
         ec_nxt = '0;
         er_nxt = er + XW'(1);
         if (er_nxt >= ch) begin
            er_nxt = '0;
         end
      end
      emit_col_in = ECB'(ec_nxt);
      emit_row_in = ERB'(er_nxt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_col_ff <= '0;
         load_row_ff <= '0;
         emit_col_ff <= '0;
         emit_row_ff <= '0;
      end else begin
         if (load_fire) begin
            load_col_ff <= load_col_in;
            load_row_ff <= load_row_in;
         end
         if (emit_fire) begin
            emit_col_ff <= emit_col_in;
            emit_row_ff <= emit_row_in;
         end
      end
   end

endmodule

// File: rtl/mqfc_check.sv
// Port-level checker for the compositor, bound to the top level.
// Depends on mqfc_pkg and mirrored_quad_framed_compositor.
module mqfc_check
   import mqfc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && (req_data.opcode == OP_EMIT), 2))
      else $error("response without an emit request two cycles earlier");

endmodule

bind mirrored_quad_framed_compositor mqfc_check u_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
